### hdl/mbe_pkg.sv
// ============================================================================
// mbe_pkg : shared types and constants of the escape-time iterator
// Fixed-point widths, limits and the control record that moves down the chain.
// ============================================================================
package mbe_pkg;

  // Q3.28 point coordinates.
  localparam int unsigned CW        = 32;
  // z after an update may reach beyond the range of c, so it carries one more bit.
  localparam int unsigned ZW        = CW + 1;
  // Full width of a square or cross product.
  localparam int unsigned PW        = 2 * CW;
  localparam int unsigned FRAC_BITS = 28;

  localparam int unsigned COUNT_W   = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam int unsigned MAX_ITER_DEF = 30;

  // 2.0 at 28 fraction bits and 4.0 at 56 fraction bits.
  localparam logic signed [ZW-1:0] TWO_FIX   = 33'sd536870912;
  localparam logic signed [PW-1:0] FOUR_WIDE = 64'sh0400_0000_0000_0000;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic [COUNT_W-1:0] count;
  } mbe_ctl_t;

endpackage

### hdl/mbe_cell.sv
// ============================================================================
// mbe_cell : one iteration of z = z*z + c
// Tests the incoming z for escape and forms the next z, over two registers.
// ============================================================================
module mbe_cell #(
  parameter int unsigned Idx = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mbe_pkg::mbe_ctl_t               ctl_i,
  input  logic signed [mbe_pkg::ZW-1:0]   zr_i,
  input  logic signed [mbe_pkg::ZW-1:0]   zi_i,
  input  logic signed [mbe_pkg::CW-1:0]   cr_i,
  input  logic signed [mbe_pkg::CW-1:0]   ci_i,
  output mbe_pkg::mbe_ctl_t               ctl_o,
  output logic signed [mbe_pkg::ZW-1:0]   zr_o,
  output logic signed [mbe_pkg::ZW-1:0]   zi_o,
  output logic signed [mbe_pkg::CW-1:0]   cr_o,
  output logic signed [mbe_pkg::CW-1:0]   ci_o
);
  import mbe_pkg::*;

  // Iteration number reported when this cell sees the first escape.
  localparam logic [COUNT_W-1:0] ESC_COUNT = (Idx > COUNT_MAX) ? COUNT_MAX : COUNT_W'(Idx);

  // Product stage.
  logic                 big_d;
  logic signed [CW-1:0] ma_r, ma_i;
  logic signed [PW-1:0] sq_r_d, sq_i_d, xy_d;
  logic signed [PW-1:0] sq_r_q, sq_i_q, xy_q;
  logic                 big_q;
  logic signed [CW-1:0] cr_q, ci_q;
  mbe_ctl_t             ctl_a_q;

  // Update stage.
  logic                 esc;
  logic signed [PW-1:0] mag;
  logic signed [PW-1:0] sh_r, sh_i;
  logic signed [ZW-1:0] zr_d, zi_d;
  mbe_ctl_t             ctl_b_d, ctl_b_q;
  logic signed [ZW-1:0] zr_q, zi_q;
  logic signed [CW-1:0] cr_b_q, ci_b_q;

  // A part beyond 2.0 already decides the test; its products are then not needed,
  // so the multiplier inputs are zeroed and stay within 32 bits.
  always_comb begin
    big_d  = (zr_i > TWO_FIX) || (zr_i < -TWO_FIX) || (zi_i > TWO_FIX) || (zi_i < -TWO_FIX);
    ma_r   = big_d ? '0 : zr_i[CW-1:0];
    ma_i   = big_d ? '0 : zi_i[CW-1:0];
    sq_r_d = ma_r * ma_r;
    sq_i_d = ma_i * ma_i;
    xy_d   = ma_r * ma_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_r_d;
    sq_i_q <= sq_i_d;
    xy_q   <= xy_d;
    big_q  <= big_d;
    cr_q   <= cr_i;
    ci_q   <= ci_i;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    cr_b_q <= cr_q;
    ci_b_q <= ci_q;
  end

  // Exact escape test, then the floor shift back to 28 fraction bits plus c.
  // The cross product is doubled by shifting one place less.
  always_comb begin
    mag     = sq_r_q + sq_i_q;
    esc     = big_q || (mag > FOUR_WIDE);
    sh_r    = (sq_r_q - sq_i_q) >>> FRAC_BITS;
    sh_i    = xy_q >>> (FRAC_BITS - 1);
    zr_d    = ZW'(sh_r) + ZW'(cr_q);
    zi_d    = ZW'(sh_i) + ZW'(ci_q);
    ctl_b_d = ctl_a_q;
    if (!ctl_a_q.done && esc) begin
      ctl_b_d.done  = 1'b1;
      ctl_b_d.count = ESC_COUNT;
    end
  end

  assign ctl_o = ctl_b_q;
  assign zr_o  = zr_q;
  assign zi_o  = zi_q;
  assign cr_o  = cr_b_q;
  assign ci_o  = ci_b_q;

endmodule

### hdl/mandelbrot_escape_time.sv
// ============================================================================
// mandelbrot_escape_time : escape-time count of one complex point
// Iterates z = z*z + c from z = 0 through a chain of cells that differ only in Idx.
// ============================================================================
// An accepted request passes every cell's product and update registers before done_o.
// Throughput: one request per cycle; each chain cell holds two points in flight.
// busy is never raised, and the result cannot be stalled by the receiver.
// Reset clears every valid flag in the chain at once; there is no clearing pass.
module mandelbrot_escape_time #(
  parameter int unsigned MAX_ITERATIONS = mbe_pkg::MAX_ITER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mbe_pkg::CW-1:0]        c_real_i,
  input  logic signed [mbe_pkg::CW-1:0]        c_imag_i,
  output logic                                 done_o,
  output logic [mbe_pkg::COUNT_W-1:0]          escape_count_o
);
  import mbe_pkg::*;

  // Total pipeline depth, used by the checks below.
  localparam int unsigned LAT = 2 * MAX_ITERATIONS;
  // Largest count that can ever be reported.
  localparam logic [COUNT_W-1:0] COUNT_TOP =
    (MAX_ITERATIONS > COUNT_MAX) ? COUNT_MAX : COUNT_W'(MAX_ITERATIONS);

  // Links between neighbouring cells. Link 0 feeds the first cell, and link
  // MAX_ITERATIONS carries the outcome of the last one.
  mbe_ctl_t             ctl_w [MAX_ITERATIONS+1];
  logic signed [ZW-1:0] zr_w  [MAX_ITERATIONS+1];
  logic signed [ZW-1:0] zi_w  [MAX_ITERATIONS+1];
  logic signed [CW-1:0] cr_w  [MAX_ITERATIONS+1];
  logic signed [CW-1:0] ci_w  [MAX_ITERATIONS+1];

  // Every cell is fully pipelined, so a request is taken in every cycle and the
  // block never signals that it is busy.
  assign busy = 1'b0;

  // Since z starts at zero, the first iteration gives z = c exactly. The first
  // cell therefore receives c as z and tests it as iteration one.
  always_comb begin
    ctl_w[0].valid = start && !busy;
    ctl_w[0].done  = 1'b0;
    ctl_w[0].count = '0;
    zr_w[0]        = ZW'(c_real_i);
    zi_w[0]        = ZW'(c_imag_i);
    cr_w[0]        = c_real_i;
    ci_w[0]        = c_imag_i;
  end

  // Cell k tests iteration k for escape and forms iteration k + 1. Once a
  // point has escaped, later cells carry its count unchanged and ignore z.
  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    mbe_cell #(
      .Idx (g + 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_w[g]),
      .zr_i   (zr_w[g]),
      .zi_i   (zi_w[g]),
      .cr_i   (cr_w[g]),
      .ci_i   (ci_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .zr_o   (zr_w[g+1]),
      .zi_o   (zi_w[g+1]),
      .cr_o   (cr_w[g+1]),
      .ci_o   (ci_w[g+1])
    );
  end

  // A point that never escaped keeps its count at zero all the way down.
  assign done_o         = ctl_w[MAX_ITERATIONS].valid;
  assign escape_count_o = ctl_w[MAX_ITERATIONS].count;

  // A result only ever leaves for a request taken exactly one pipeline depth earlier.
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  // The reported count never exceeds the iteration limit.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (escape_count_o <= COUNT_TOP))
    else $error("escape count beyond the iteration limit");

  // A point whose real part lies beyond 2.0 escapes at the first iteration.
  a_large_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past((ZW'(c_real_i) > TWO_FIX) || (ZW'(c_real_i) < -TWO_FIX), LAT))
      |-> (escape_count_o == COUNT_W'(1)))
    else $error("large point did not escape at once");

  // Flags of a point that has escaped are never lost in the chain.
  a_done_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (escape_count_o != '0)) |-> ctl_w[MAX_ITERATIONS].done)
    else $error("nonzero count without an escape flag");

endmodule
